### hw/rtl/llcp_pkg.sv
package llcp_pkg;

    // Coordinate format: signed fixed point, FRAC_BITS of COORD_WIDTH bits are fraction.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Threshold register: unsigned, THRESH_FRAC fraction bits.
    localparam int THRESH_WIDTH = 40;
    localparam int THRESH_FRAC  = 32;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(429497);

    // Width of one slice of a multiplier operand.
    localparam int LIMB_BITS = 32;

    // Derived widths of the exact intermediate values.
    localparam int VEC_W  = COORD_WIDTH + 1;        // u, v, w
    localparam int DOT_W  = 2 * VEC_W + 2;          // a, b, c, d, e
    localparam int DET_W  = 2 * DOT_W + 1;          // D and the numerator N
    localparam int PROD_W = VEC_W + DET_W;          // u_i * N
    localparam int QUO_W  = COORD_WIDTH + 2;        // quotient bits kept

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] line_a_start_x;
        logic signed [COORD_WIDTH-1:0] line_a_start_y;
        logic signed [COORD_WIDTH-1:0] line_a_start_z;
        logic signed [COORD_WIDTH-1:0] line_a_end_x;
        logic signed [COORD_WIDTH-1:0] line_a_end_y;
        logic signed [COORD_WIDTH-1:0] line_a_end_z;
        logic signed [COORD_WIDTH-1:0] line_b_start_x;
        logic signed [COORD_WIDTH-1:0] line_b_start_y;
        logic signed [COORD_WIDTH-1:0] line_b_start_z;
        logic signed [COORD_WIDTH-1:0] line_b_end_x;
        logic signed [COORD_WIDTH-1:0] line_b_end_y;
        logic signed [COORD_WIDTH-1:0] line_b_end_z;
    } req_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] closest_x;
        logic signed [COORD_WIDTH-1:0] closest_y;
        logic signed [COORD_WIDTH-1:0] closest_z;
        logic                          nearly_parallel;
        logic                          saturated;
    } rsp_t;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

endpackage

### hw/rtl/llcp_mul.sv
module llcp_mul #(
    parameter int WA = llcp_pkg::VEC_W,
    parameter int WB = llcp_pkg::VEC_W
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [WA-1:0]  a,
    input  logic signed [WB-1:0]  b,
    output logic signed [WA+WB-1:0] p
);
    import llcp_pkg::*;

    // Sign and magnitude, limb products, row sums, final sum: four register stages.
    localparam int LB = LIMB_BITS;
    localparam int NA = (WA + LB - 1) / LB;
    localparam int NB = (WB + LB - 1) / LB;
    localparam int IW = (NA + NB) * LB;
    localparam int PW = WA + WB;

    logic [WA-1:0]      abs_a;
    logic [WB-1:0]      abs_b;
    logic [NA*LB-1:0]   ma_reg;
    logic [NB*LB-1:0]   mb_reg;
    logic               sa_reg;
    logic               sb_reg;
    logic               sc_reg;
    logic [2*LB-1:0]    pp_reg [NA][NB];
    logic [IW-1:0]      row_next [NA];
    logic [IW-1:0]      row_reg [NA];
    logic [IW-1:0]      sum_next;
    logic signed [PW-1:0] p_reg;

    always_comb
    begin
        abs_a = a[WA-1] ? WA'(-a) : a;
        abs_b = b[WB-1] ? WB'(-b) : b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg <= (NA*LB)'(abs_a);
            mb_reg <= (NB*LB)'(abs_b);
            sa_reg <= a[WA-1] ^ b[WB-1];
        end
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_row
        for (genvar j = 0; j < NB; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[i][j] <= ma_reg[i*LB +: LB] * mb_reg[j*LB +: LB];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg <= sa_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (IW'(pp_reg[i][j]) << (j * LB));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg <= row_next;
            sc_reg  <= sb_reg;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (row_reg[i] << (i * LB));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= sc_reg ? -$signed(sum_next[PW-1:0]) : $signed(sum_next[PW-1:0]);
        end
    end

    assign p = p_reg;

endmodule

### hw/rtl/llcp_div.sv
module llcp_div #(
    parameter int PRW = llcp_pkg::PROD_W,
    parameter int DWD = llcp_pkg::DET_W,
    parameter int QB  = llcp_pkg::QUO_W,
    parameter int TW  = llcp_pkg::COORD_WIDTH
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [PRW-1:0] prod,
    input  logic signed [DWD-1:0] det,
    input  logic [TW-1:0]         tag,
    output logic [QB-1:0]         quo,
    output logic                  neg,
    output logic                  ovf,
    output logic [TW-1:0]         tag_out
);
    import llcp_pkg::*;

    // Rounded quotient (2|prod| + det) / (2 det), one quotient bit per stage.
    localparam int NW = PRW + 2;
    localparam int XW = imax(NW, DWD + 1 + QB) + 1;

    logic [PRW-1:0] mag;
    logic [XW-1:0]  num0;
    logic [XW-1:0]  den0;

    logic [XW-1:0]  rem_reg [QB+1];
    logic [XW-1:0]  den_reg [QB+1];
    logic [QB-1:0]  quo_reg [QB+1];
    logic           neg_reg [QB+1];
    logic           ovf_reg [QB+1];
    logic [TW-1:0]  tag_reg [QB+1];

    always_comb
    begin
        mag  = prod[PRW-1] ? PRW'(-prod) : prod;
        num0 = (XW'(mag) << 1) + XW'($unsigned(det));
        den0 = XW'($unsigned(det)) << 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num0;
            den_reg[0] <= den0;
            quo_reg[0] <= '0;
            neg_reg[0] <= prod[PRW-1];
            ovf_reg[0] <= num0 >= (den0 << QB);
            tag_reg[0] <= tag;
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [XW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = den_reg[k-1] << (QB - k);
            take  = rem_reg[k-1] >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                quo_reg[k] <= quo_reg[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign quo     = quo_reg[QB];
    assign neg     = neg_reg[QB];
    assign ovf     = ovf_reg[QB];
    assign tag_out = tag_reg[QB];

endmodule

### hw/rtl/line_line_closest_point.sv
// Throughput: one request per cycle; the depth is set by the three chained multiplier
// stages and the restoring divider, which resolves one quotient bit per stage.
// While a result waits at the output the whole pipeline holds and requests are stalled.
// Reset clears all valid bits and loads the parallel threshold with its reset value.
module line_line_closest_point (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [llcp_pkg::THRESH_WIDTH-1:0]    cfg_data,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  llcp_pkg::req_t                       req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output llcp_pkg::rsp_t                       rsp
);
    import llcp_pkg::*;

    // Stage map (index of the valid bit that goes with each register):
    //   0           u = A2 - A1, v = B2 - B1, w = A1 - B1
    //   1..4        fifteen component products
    //   5           dot products a, b, c, d, e
    //   6..9        products a*c, b*b, b*e, c*d
    //   10          determinant D and numerator N
    //   11          parallel decision; 11..14 products u_i * N
    //   15..15+QB   rounded division, one quotient bit per stage
    //   16+QB       saturation and the output register
    localparam int CW      = COORD_WIDTH;
    localparam int QB      = QUO_W;
    localparam int LAT     = QB + 17;
    localparam int U_DLY   = 10;
    localparam int A1_DLY  = 14;
    localparam int DET_DLY = 4;
    localparam int PAR_DLY = QB + 5;
    localparam int TSH     = 4 * FRAC_BITS - THRESH_FRAC;
    localparam int CMPW    = imax(DET_W, THRESH_WIDTH + TSH) + 1;
    localparam logic signed [CW+3:0] MAXV = {{5{1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [CW+3:0] MINV = {{5{1'b1}}, {(CW-1){1'b0}}};

    logic en;
    logic vld_reg [LAT];
    logic [THRESH_WIDTH-1:0] thr_reg;

    logic signed [CW-1:0]      a1_in [3];
    logic signed [CW-1:0]      a2_in [3];
    logic signed [CW-1:0]      b1_in [3];
    logic signed [CW-1:0]      b2_in [3];
    logic signed [VEC_W-1:0]   u_reg [3];
    logic signed [VEC_W-1:0]   v_reg [3];
    logic signed [VEC_W-1:0]   w_reg [3];
    logic signed [CW-1:0]      a1_reg [3];

    logic signed [VEC_W-1:0]   u_pipe_reg [U_DLY][3];
    logic signed [CW-1:0]      a1_pipe_reg [A1_DLY][3];

    logic signed [2*VEC_W-1:0] p_uu [3];
    logic signed [2*VEC_W-1:0] p_uv [3];
    logic signed [2*VEC_W-1:0] p_vv [3];
    logic signed [2*VEC_W-1:0] p_uw [3];
    logic signed [2*VEC_W-1:0] p_vw [3];

    logic signed [DOT_W-1:0]   dot_a_reg;
    logic signed [DOT_W-1:0]   dot_b_reg;
    logic signed [DOT_W-1:0]   dot_c_reg;
    logic signed [DOT_W-1:0]   dot_d_reg;
    logic signed [DOT_W-1:0]   dot_e_reg;

    logic signed [2*DOT_W-1:0] p_ac;
    logic signed [2*DOT_W-1:0] p_bb;
    logic signed [2*DOT_W-1:0] p_be;
    logic signed [2*DOT_W-1:0] p_cd;

    logic signed [DET_W-1:0]   det_reg;
    logic signed [DET_W-1:0]   num_reg;
    logic signed [DET_W-1:0]   det_pipe_reg [DET_DLY];
    logic                      par_pipe_reg [PAR_DLY];
    logic signed [CMPW-1:0]    det_cmp;
    logic signed [CMPW-1:0]    thr_cmp;
    logic                      par_next;

    logic signed [PROD_W-1:0]  p_off [3];
    logic [QB-1:0]             quo [3];
    logic                      qneg [3];
    logic                      qovf [3];
    logic [CW-1:0]             a1_out [3];

    logic signed [CW-1:0]      res_next [3];
    logic                      clip [3];
    rsp_t                      rsp_reg;

    // The pipeline moves as one; it holds only while a finished result is refused.
    assign en        = !(vld_reg[LAT-1] && rsp_stall);
    assign req_stall = !en;
    assign rsp_valid = vld_reg[LAT-1];
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= req_valid;
            for (int k = 1; k < LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Difference vectors, one bit wider than the coordinates so they stay exact.
    always_comb
    begin
        a1_in[0] = req.line_a_start_x;
        a1_in[1] = req.line_a_start_y;
        a1_in[2] = req.line_a_start_z;
        a2_in[0] = req.line_a_end_x;
        a2_in[1] = req.line_a_end_y;
        a2_in[2] = req.line_a_end_z;
        b1_in[0] = req.line_b_start_x;
        b1_in[1] = req.line_b_start_y;
        b1_in[2] = req.line_b_start_z;
        b2_in[0] = req.line_b_end_x;
        b2_in[1] = req.line_b_end_y;
        b2_in[2] = req.line_b_end_z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i]  <= VEC_W'(a2_in[i]) - VEC_W'(a1_in[i]);
                v_reg[i]  <= VEC_W'(b2_in[i]) - VEC_W'(b1_in[i]);
                w_reg[i]  <= VEC_W'(a1_in[i]) - VEC_W'(b1_in[i]);
                a1_reg[i] <= a1_in[i];
            end
        end
    end

    // Delay lines that keep u and A1 in step with the arithmetic.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_pipe_reg[0]  <= u_reg;
            a1_pipe_reg[0] <= a1_reg;
            for (int k = 1; k < U_DLY; k++)
            begin
                u_pipe_reg[k] <= u_pipe_reg[k-1];
            end
            for (int k = 1; k < A1_DLY; k++)
            begin
                a1_pipe_reg[k] <= a1_pipe_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        llcp_mul #(.WA(VEC_W), .WB(VEC_W)) u_mul_uu (
            .clk (clk), .en (en), .a (u_reg[i]), .b (u_reg[i]), .p (p_uu[i])
        );
        llcp_mul #(.WA(VEC_W), .WB(VEC_W)) u_mul_uv (
            .clk (clk), .en (en), .a (u_reg[i]), .b (v_reg[i]), .p (p_uv[i])
        );
        llcp_mul #(.WA(VEC_W), .WB(VEC_W)) u_mul_vv (
            .clk (clk), .en (en), .a (v_reg[i]), .b (v_reg[i]), .p (p_vv[i])
        );
        llcp_mul #(.WA(VEC_W), .WB(VEC_W)) u_mul_uw (
            .clk (clk), .en (en), .a (u_reg[i]), .b (w_reg[i]), .p (p_uw[i])
        );
        llcp_mul #(.WA(VEC_W), .WB(VEC_W)) u_mul_vw (
            .clk (clk), .en (en), .a (v_reg[i]), .b (w_reg[i]), .p (p_vw[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_a_reg <= DOT_W'(p_uu[0]) + DOT_W'(p_uu[1]) + DOT_W'(p_uu[2]);
            dot_b_reg <= DOT_W'(p_uv[0]) + DOT_W'(p_uv[1]) + DOT_W'(p_uv[2]);
            dot_c_reg <= DOT_W'(p_vv[0]) + DOT_W'(p_vv[1]) + DOT_W'(p_vv[2]);
            dot_d_reg <= DOT_W'(p_uw[0]) + DOT_W'(p_uw[1]) + DOT_W'(p_uw[2]);
            dot_e_reg <= DOT_W'(p_vw[0]) + DOT_W'(p_vw[1]) + DOT_W'(p_vw[2]);
        end
    end

    llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_ac (
        .clk (clk), .en (en), .a (dot_a_reg), .b (dot_c_reg), .p (p_ac)
    );
    llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_bb (
        .clk (clk), .en (en), .a (dot_b_reg), .b (dot_b_reg), .p (p_bb)
    );
    llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_be (
        .clk (clk), .en (en), .a (dot_b_reg), .b (dot_e_reg), .p (p_be)
    );
    llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_cd (
        .clk (clk), .en (en), .a (dot_c_reg), .b (dot_d_reg), .p (p_cd)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= DET_W'(p_ac) - DET_W'(p_bb);
            num_reg <= DET_W'(p_be) - DET_W'(p_cd);
        end
    end

    // The threshold is brought up to the determinant's fraction bits before the
    // compare. A zero determinant always counts as parallel, so the divider never
    // sees a zero divisor on a result that is used.
    always_comb
    begin
        det_cmp  = CMPW'(det_reg);
        thr_cmp  = $signed(CMPW'(thr_reg) << TSH);
        par_next = (det_cmp < thr_cmp) || (det_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_pipe_reg[0] <= det_reg;
            par_pipe_reg[0] <= par_next;
            for (int k = 1; k < DET_DLY; k++)
            begin
                det_pipe_reg[k] <= det_pipe_reg[k-1];
            end
            for (int k = 1; k < PAR_DLY; k++)
            begin
                par_pipe_reg[k] <= par_pipe_reg[k-1];
            end
        end
    end

    // Each offset u_i * N / D is one exact quotient, rounded half away from zero.
    for (genvar i = 0; i < 3; i++)
    begin : g_off
        llcp_mul #(.WA(VEC_W), .WB(DET_W)) u_mul_off (
            .clk (clk),
            .en  (en),
            .a   (u_pipe_reg[U_DLY-1][i]),
            .b   (num_reg),
            .p   (p_off[i])
        );

        llcp_div #(.PRW(PROD_W), .DWD(DET_W), .QB(QB), .TW(CW)) u_div (
            .clk     (clk),
            .en      (en),
            .prod    (p_off[i]),
            .det     (det_pipe_reg[DET_DLY-1]),
            .tag     (a1_pipe_reg[A1_DLY-1][i]),
            .quo     (quo[i]),
            .neg     (qneg[i]),
            .ovf     (qovf[i]),
            .tag_out (a1_out[i])
        );
    end

    // Add the offset to A1 and clip (a parallel result keeps A1). A quotient that did
    // not fit the kept bits is far outside the coordinate range, so it clips to its sign.
    always_comb
    begin
        logic signed [CW+2:0] qs;
        logic signed [CW+3:0] sum_w;
        for (int i = 0; i < 3; i++)
        begin
            qs    = $signed({1'b0, quo[i]});
            qs    = qneg[i] ? -qs : qs;
            sum_w = (CW+4)'($signed(a1_out[i])) + (CW+4)'(qs);
            if (par_pipe_reg[PAR_DLY-1])
            begin
                res_next[i] = $signed(a1_out[i]);
                clip[i]     = 1'b0;
            end
            else if (qovf[i])
            begin
                res_next[i] = qneg[i] ? MINV[CW-1:0] : MAXV[CW-1:0];
                clip[i]     = 1'b1;
            end
            else if (sum_w > MAXV)
            begin
                res_next[i] = MAXV[CW-1:0];
                clip[i]     = 1'b1;
            end
            else if (sum_w < MINV)
            begin
                res_next[i] = MINV[CW-1:0];
                clip[i]     = 1'b1;
            end
            else
            begin
                res_next[i] = sum_w[CW-1:0];
                clip[i]     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg.closest_x       <= res_next[0];
            rsp_reg.closest_y       <= res_next[1];
            rsp_reg.closest_z       <= res_next[2];
            rsp_reg.nearly_parallel <= par_pipe_reg[PAR_DLY-1];
            rsp_reg.saturated       <= clip[0] | clip[1] | clip[2];
        end
    end

    // Requests are only held off while a finished result is being refused.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled without a refused result");

    // A parallel result takes A1 unchanged and can never be clipped.
    a_par_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.nearly_parallel && rsp.saturated))
        else $error("parallel result marked as saturated");

    // u.u is a sum of squares.
    a_dot_a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[5] |-> !dot_a_reg[DOT_W-1])
        else $error("negative squared length");

    // By Cauchy-Schwarz the exact determinant is never negative.
    a_det_pos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[10] |-> !det_reg[DET_W-1])
        else $error("negative determinant");

endmodule
